// ===== rtl/core/cjb_pkg.sv =====
// Shared constants, state type and index tables for the contact Jacobian builder.
package cjb_pkg;

  localparam int DEF_VALUE_WIDTH = 32;
  localparam int DEF_FRAC_BITS   = 16;
  localparam int NUM_SLOTS       = 32;
  localparam int SLOT_W          = 5;
  localparam int LOAD_SLOTS      = 14;
  localparam int SLOT_I0         = 14;
  localparam int SLOT_I1         = 23;
  localparam longint unsigned FIVE_POW_12 = 64'd244140625;

  // Matrix, row and part codes on the result ports
  localparam logic [1:0] MAT_J0      = 2'd0;
  localparam logic [1:0] MAT_J1      = 2'd1;
  localparam logic [1:0] MAT_J0_MINV = 2'd2;
  localparam logic [1:0] MAT_J1_MINV = 2'd3;
  localparam logic [1:0] ROW_N       = 2'd0;
  localparam logic [1:0] ROW_T       = 2'd1;
  localparam logic [1:0] ROW_B       = 2'd2;
  localparam logic       PART_LIN    = 1'b0;
  localparam logic       PART_ANG    = 1'b1;

  // Which frame vector the normalizer is working on
  localparam logic NM_TAN = 1'b0;
  localparam logic NM_BIN = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_PREP,
    S_NSQ,
    S_SQRT,
    S_NDIV,
    S_NFIN,
    S_BCROSS,
    S_RCP,
    S_ROW,
    S_EMIT
  } cjb_state_t;

  // Cross product: product q uses a[cr_ia(q)] * b[cr_ib(q)]
  function automatic logic [1:0] cr_ia(input logic [2:0] q);
    case (q)
      3'd0: return 2'd1;
      3'd1: return 2'd2;
      3'd2: return 2'd2;
      3'd3: return 2'd0;
      3'd4: return 2'd0;
      default: return 2'd1;
    endcase
  endfunction

  function automatic logic [1:0] cr_ib(input logic [2:0] q);
    case (q)
      3'd0: return 2'd2;
      3'd1: return 2'd1;
      3'd2: return 2'd0;
      3'd3: return 2'd2;
      3'd4: return 2'd1;
      default: return 2'd0;
    endcase
  endfunction

  // Row times matrix: product q uses row element k, column j, entry 3k+j
  function automatic logic [1:0] mat_k(input logic [3:0] q);
    case (q)
      4'd0, 4'd3, 4'd6: return 2'd0;
      4'd1, 4'd4, 4'd7: return 2'd1;
      default: return 2'd2;
    endcase
  endfunction

  function automatic logic [1:0] mat_j(input logic [3:0] q);
    case (q)
      4'd0, 4'd1, 4'd2: return 2'd0;
      4'd3, 4'd4, 4'd5: return 2'd1;
      default: return 2'd2;
    endcase
  endfunction

  function automatic logic [3:0] mat_off(input logic [3:0] q);
    case (q)
      4'd0: return 4'd0;
      4'd1: return 4'd3;
      4'd2: return 4'd6;
      4'd3: return 4'd1;
      4'd4: return 4'd4;
      4'd5: return 4'd7;
      4'd6: return 4'd2;
      4'd7: return 4'd5;
      default: return 4'd8;
    endcase
  endfunction

endpackage

// ===== rtl/core/contact_jacobian_builder_core.sv =====
// Contact Jacobian builder: operand store, frame normalization and row emission sequencer.
// A load beat (compute low) only writes the store; busy stays low and the next beat may follow.
// A compute beat keeps busy high until the last of the 24 rows; at Q16.16 the work is
// dominated by the bit-serial divider (eight quotients) and the square root (run twice).
// Synchronous reset returns the sequencer to idle; the operand store is not cleared.
module contact_jacobian_builder_core #(
  parameter int VALUE_WIDTH = cjb_pkg::DEF_VALUE_WIDTH,
  parameter int FRAC_BITS   = cjb_pkg::DEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [cjb_pkg::SLOT_W-1:0]    slot,
  input  logic signed [VALUE_WIDTH-1:0] operand_value,
  input  logic                          compute,
  output logic                          strobe,
  output logic [1:0]                    which_matrix,
  output logic [1:0]                    row,
  output logic                          part,
  output logic signed [VALUE_WIDTH-1:0] value_x,
  output logic signed [VALUE_WIDTH-1:0] value_y,
  output logic signed [VALUE_WIDTH-1:0] value_z,
  output logic                          last
);

  localparam int VW   = VALUE_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int PW   = 2 * VW;
  localparam int SW   = PW + 2;
  localparam int NSW  = PW + 2;
  localparam int RW   = VW + 1;
  localparam int DIVW = (VW + F > 2 * F + 1) ? VW + F : 2 * F + 1;
  localparam int CNTW = $clog2(RW + 16);
  localparam int AW   = cjb_pkg::SLOT_W;

  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [SW-1:0] VMAX_W = {{(SW-VW+1){1'b0}}, {(VW-1){1'b1}}};
  localparam logic signed [SW-1:0] VMIN_W = {{(SW-VW+1){1'b1}}, {(VW-1){1'b0}}};
  localparam logic [NSW-1:0] EPS_SQ =
    NSW'((64'd1 << (2 * F - 12)) / cjb_pkg::FIVE_POW_12);
  localparam logic [DIVW-1:0] RCP_NUM = DIVW'(1) << (2 * F);

  // Saturating fixed-point helpers
  function automatic logic signed [VW-1:0] sat_w(input logic signed [SW-1:0] v);
    if (v > VMAX_W) return VMAX;
    if (v < VMIN_W) return VW'(VMIN_W);
    return VW'(v);
  endfunction

  function automatic logic signed [SW-1:0] ext(input logic signed [VW-1:0] a);
    return {{(SW-VW){a[VW-1]}}, a};
  endfunction

  function automatic logic signed [VW-1:0] f_sub(input logic signed [VW-1:0] a,
                                                 input logic signed [VW-1:0] c);
    return sat_w(ext(a) - ext(c));
  endfunction

  function automatic logic signed [VW-1:0] f_add(input logic signed [VW-1:0] a,
                                                 input logic signed [VW-1:0] c);
    return sat_w(ext(a) + ext(c));
  endfunction

  function automatic logic signed [VW-1:0] f_neg(input logic signed [VW-1:0] a);
    return sat_w(SW'(0) - ext(a));
  endfunction

  function automatic logic signed [VW-1:0] f_mul(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    s = p >>> F;
    return sat_w({{2{s[PW-1]}}, s});
  endfunction

  function automatic logic [VW-1:0] mag(input logic signed [VW-1:0] a);
    return a[VW-1] ? VW'(-a) : VW'(a);
  endfunction

  cjb_pkg::cjb_state_t state, state_next;

  // Operand store
  logic [VW-1:0] store [cjb_pkg::NUM_SLOTS];
  logic [VW-1:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic          acc_in;

  // Working registers
  logic signed [VW-1:0] opd [cjb_pkg::LOAD_SLOTS];
  logic signed [VW-1:0] r0 [3];
  logic signed [VW-1:0] r1 [3];
  logic signed [VW-1:0] t [3];
  logic signed [VW-1:0] b [3];
  logic signed [VW-1:0] nv [3];
  logic signed [VW-1:0] ov [3];
  logic signed [VW-1:0] ja0 [3][3];
  logic signed [VW-1:0] ja1 [3][3];
  logic signed [VW-1:0] im0, im1, cfirst, acc;
  logic signed [PW-1:0] prod_q;
  logic [NSW-1:0]       nsq, nsq_sum, sq_x;
  logic [RW+1:0]        sq_rem, rem_sh, trial;
  logic [RW-1:0]        sq_root;
  logic                 sq_ge;

  // Sequencer control
  logic [CNTW-1:0] step;
  logic [3:0]      qs, qa, qm;
  logic [1:0]      ci, rm, rr;
  logic            rp, nmode, tan_fb, div_wait;
  logic            nsq_retry, row_done, last_row, step_clr;
  logic [2:0]      kind;

  // Shared multiplier and divider
  logic signed [VW-1:0] mul_a, mul_b, fm;
  logic signed [VW-1:0] frame_v [3];
  logic signed [VW-1:0] cr_a [3];
  logic signed [VW-1:0] cr_b [3];
  logic signed [VW-1:0] m_sel, div_sv, rcp_val;
  logic                 div_start, div_done, rcp_step;
  logic [DIVW-1:0]      div_dvd;
  logic [VW-1:0]        div_dvs, div_q;

  assign acc_in = start && !busy;
  assign qs     = step[3:0];
  assign qa     = 4'(step - CNTW'(1));
  assign qm     = 4'(step - CNTW'(2));
  assign kind   = {rm, rp};
  assign fm     = f_mul(prod_q);
  assign m_sel  = ci[0] ? opd[13] : opd[12];
  assign last_row = (rm == cjb_pkg::MAT_J1_MINV) && (rr == cjb_pkg::ROW_B) &&
                    (rp == cjb_pkg::PART_ANG);

  // Store write on each accepted beat, registered read
  always_ff @(posedge clk) begin
    if (acc_in) begin
      store[slot] <= operand_value;
    end
    rd_data <= store[rd_addr];
  end

  always_comb begin
    rd_addr = '0;
    if (state == cjb_pkg::S_LOAD) begin
      rd_addr = AW'(step);
    end else if (state == cjb_pkg::S_ROW && rp == cjb_pkg::PART_ANG) begin
      if (rm == cjb_pkg::MAT_J0_MINV) begin
        rd_addr = AW'(cjb_pkg::SLOT_I0) + AW'(cjb_pkg::mat_off(qs));
      end else begin
        rd_addr = AW'(cjb_pkg::SLOT_I1) + AW'(cjb_pkg::mat_off(qs));
      end
    end
  end

  // Frame row selected by the row counter
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (rr)
        cjb_pkg::ROW_N: frame_v[i] = opd[3+i];
        cjb_pkg::ROW_T: frame_v[i] = t[i];
        default:        frame_v[i] = b[i];
      endcase
      cr_a[i] = (state == cjb_pkg::S_BCROSS) ? opd[3+i] :
                (rm == cjb_pkg::MAT_J0) ? r0[i] : r1[i];
      cr_b[i] = (state == cjb_pkg::S_BCROSS) ? t[i] : frame_v[i];
    end
  end

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      cjb_pkg::S_NSQ: begin
        if (step < CNTW'(3)) begin
          mul_a = nv[step[1:0]];
          mul_b = nv[step[1:0]];
        end
      end
      cjb_pkg::S_BCROSS: begin
        mul_a = cr_a[cjb_pkg::cr_ia(step[2:0])];
        mul_b = cr_b[cjb_pkg::cr_ib(step[2:0])];
      end
      cjb_pkg::S_ROW: begin
        if (rp == cjb_pkg::PART_ANG) begin
          if (rm == cjb_pkg::MAT_J0 || rm == cjb_pkg::MAT_J1) begin
            mul_a = cr_a[cjb_pkg::cr_ia(step[2:0])];
            mul_b = cr_b[cjb_pkg::cr_ib(step[2:0])];
          end else begin
            mul_a = (rm == cjb_pkg::MAT_J0_MINV) ? ja0[rr][cjb_pkg::mat_k(qa)] :
                                                   ja1[rr][cjb_pkg::mat_k(qa)];
            mul_b = $signed(rd_data);
          end
        end else if (step < CNTW'(3)) begin
          if (rm == cjb_pkg::MAT_J0_MINV) begin
            mul_a = im0;
            mul_b = frame_v[step[1:0]];
          end else if (rm == cjb_pkg::MAT_J1_MINV) begin
            mul_a = im1;
            mul_b = f_neg(frame_v[step[1:0]]);
          end
        end
      end
      default: ;
    endcase
  end

  // Squared norm and one root bit per cycle
  assign nsq_sum = nsq + {2'b00, prod_q};
  assign rem_sh  = {sq_rem[RW-1:0], sq_x[NSW-1 -: 2]};
  assign trial   = {sq_root, 2'b01};
  assign sq_ge   = rem_sh >= trial;
  assign nsq_retry = (state == cjb_pkg::S_NSQ) && (step == CNTW'(3)) &&
                     (nmode == cjb_pkg::NM_TAN) && !tan_fb && (nsq_sum <= EPS_SQ);

  // Divider requests: component over norm, or reciprocal mass
  assign rcp_step  = (state == cjb_pkg::S_RCP) && ((m_sel == '0) || div_done);
  assign div_start = !div_wait &&
                     (((state == cjb_pkg::S_NDIV) && (sq_root != '0)) ||
                      ((state == cjb_pkg::S_RCP) && (m_sel != '0)));
  assign div_dvd   = (state == cjb_pkg::S_NDIV) ? (DIVW'(mag(nv[ci])) << F) : RCP_NUM;
  assign div_dvs   = (state == cjb_pkg::S_NDIV) ? sq_root[VW-1:0] : mag(m_sel);
  assign div_sv    = nv[ci][VW-1] ? f_neg($signed(div_q)) : $signed(div_q);
  assign rcp_val   = (m_sel == '0) ? VMAX :
                     m_sel[VW-1] ? f_neg($signed(div_q)) : $signed(div_q);

  cjb_div #(
    .VALUE_WIDTH(VW),
    .DIV_WIDTH  (DIVW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dvd),
    .divisor (div_dvs),
    .done    (div_done),
    .quotient(div_q)
  );

  // Row completion by kind
  always_comb begin
    case (kind)
      3'b000, 3'b010: row_done = 1'b1;
      3'b001, 3'b011: row_done = (step == CNTW'(6));
      3'b100, 3'b110: row_done = (step == CNTW'(3));
      default:        row_done = (step == CNTW'(10));
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      cjb_pkg::S_IDLE:   if (acc_in && compute) state_next = cjb_pkg::S_LOAD;
      cjb_pkg::S_LOAD:   if (step == CNTW'(cjb_pkg::LOAD_SLOTS)) state_next = cjb_pkg::S_PREP;
      cjb_pkg::S_PREP:   state_next = cjb_pkg::S_NSQ;
      cjb_pkg::S_NSQ:    if (step == CNTW'(3) && !nsq_retry) state_next = cjb_pkg::S_SQRT;
      cjb_pkg::S_SQRT:   if (step == CNTW'(RW - 1)) state_next = cjb_pkg::S_NDIV;
      cjb_pkg::S_NDIV: begin
        if ((sq_root == '0) || (div_done && ci == 2'd2)) state_next = cjb_pkg::S_NFIN;
      end
      cjb_pkg::S_NFIN: begin
        state_next = (nmode == cjb_pkg::NM_TAN) ? cjb_pkg::S_BCROSS : cjb_pkg::S_RCP;
      end
      cjb_pkg::S_BCROSS: if (step == CNTW'(6)) state_next = cjb_pkg::S_NSQ;
      cjb_pkg::S_RCP:    if (rcp_step && ci == 2'd1) state_next = cjb_pkg::S_ROW;
      cjb_pkg::S_ROW:    if (row_done) state_next = cjb_pkg::S_EMIT;
      cjb_pkg::S_EMIT:   state_next = last_row ? cjb_pkg::S_IDLE : cjb_pkg::S_ROW;
      default:           state_next = cjb_pkg::S_IDLE;
    endcase
  end

  // Port outputs
  always_comb begin
    busy         = (state != cjb_pkg::S_IDLE);
    strobe       = (state == cjb_pkg::S_EMIT);
    last         = strobe && last_row;
    which_matrix = rm;
    row          = rr;
    part         = rp;
    value_x      = ov[0];
    value_y      = ov[1];
    value_z      = ov[2];
  end

  assign step_clr = (state_next != state) || nsq_retry;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= cjb_pkg::S_IDLE;
      step     <= '0;
      ci       <= '0;
      rm       <= '0;
      rr       <= '0;
      rp       <= 1'b0;
      nmode    <= cjb_pkg::NM_TAN;
      tan_fb   <= 1'b0;
      div_wait <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_clr ? '0 : step + 1'b1;
      if (div_start) div_wait <= 1'b1;
      if (div_done)  div_wait <= 1'b0;
      case (state)
        cjb_pkg::S_IDLE: begin
          rm <= cjb_pkg::MAT_J0;
          rr <= cjb_pkg::ROW_N;
          rp <= cjb_pkg::PART_LIN;
        end
        cjb_pkg::S_PREP: begin
          nmode  <= cjb_pkg::NM_TAN;
          tan_fb <= 1'b0;
        end
        cjb_pkg::S_NSQ:    if (nsq_retry) tan_fb <= 1'b1;
        cjb_pkg::S_SQRT:   ci <= '0;
        cjb_pkg::S_NDIV:   if (div_done) ci <= ci + 1'b1;
        cjb_pkg::S_NFIN:   ci <= '0;
        cjb_pkg::S_BCROSS: nmode <= cjb_pkg::NM_BIN;
        cjb_pkg::S_RCP:    if (rcp_step) ci <= ci + 1'b1;
        cjb_pkg::S_EMIT: begin
          rp <= ~rp;
          if (rp == cjb_pkg::PART_ANG) begin
            if (rr == cjb_pkg::ROW_B) begin
              rr <= cjb_pkg::ROW_N;
              rm <= rm + 1'b1;
            end else begin
              rr <= rr + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    prod_q <= mul_a * mul_b;
    case (state)
      cjb_pkg::S_LOAD: begin
        if (step != '0) opd[qa] <= $signed(rd_data);
      end
      cjb_pkg::S_PREP: begin
        for (int i = 0; i < 3; i++) begin
          r0[i] <= f_sub(opd[i], opd[6+i]);
          r1[i] <= f_sub(opd[i], opd[9+i]);
        end
        // t = n x z
        nv[0] <= opd[4];
        nv[1] <= f_neg(opd[3]);
        nv[2] <= '0;
      end
      cjb_pkg::S_NSQ: begin
        nsq <= (step == '0) ? '0 : nsq_sum;
        if (step == CNTW'(3)) begin
          sq_x    <= nsq_sum;
          sq_rem  <= '0;
          sq_root <= '0;
          // Degenerate tangent: fall back to n x x
          if (nsq_retry) begin
            nv[0] <= '0;
            nv[1] <= opd[5];
            nv[2] <= f_neg(opd[4]);
          end
        end
      end
      cjb_pkg::S_SQRT: begin
        sq_rem  <= sq_ge ? (rem_sh - trial) : rem_sh;
        sq_root <= {sq_root[RW-2:0], sq_ge};
        sq_x    <= sq_x << 2;
      end
      cjb_pkg::S_NDIV: begin
        if (sq_root == '0) begin
          for (int i = 0; i < 3; i++) nv[i] <= '0;
        end else if (div_done) begin
          nv[ci] <= div_sv;
        end
      end
      cjb_pkg::S_NFIN: begin
        for (int i = 0; i < 3; i++) begin
          if (nmode == cjb_pkg::NM_TAN) t[i] <= nv[i];
          else b[i] <= nv[i];
        end
      end
      cjb_pkg::S_BCROSS: begin
        if (step != '0) begin
          if (!qa[0]) cfirst <= fm;
          else nv[qa[2:1]] <= f_sub(cfirst, fm);
        end
      end
      cjb_pkg::S_RCP: begin
        if (rcp_step) begin
          if (ci == 2'd0) im0 <= rcp_val;
          else im1 <= rcp_val;
        end
      end
      cjb_pkg::S_ROW: begin
        case (kind)
          3'b000: for (int i = 0; i < 3; i++) ov[i] <= frame_v[i];
          3'b010: for (int i = 0; i < 3; i++) ov[i] <= f_neg(frame_v[i]);
          3'b001, 3'b011: begin
            if (step != '0) begin
              if (!qa[0]) cfirst <= fm;
              else if (rm == cjb_pkg::MAT_J0) ov[qa[2:1]] <= f_sub(cfirst, fm);
              else ov[qa[2:1]] <= f_neg(f_sub(cfirst, fm));
            end
          end
          3'b100, 3'b110: begin
            if (step != '0) ov[qa[1:0]] <= fm;
          end
          default: begin
            // Row times inverse inertia, saturating sum in column order
            if (step >= CNTW'(2)) begin
              if (cjb_pkg::mat_k(qm) == 2'd0) acc <= fm;
              else acc <= f_add(acc, fm);
              if (cjb_pkg::mat_k(qm) == 2'd2) ov[cjb_pkg::mat_j(qm)] <= f_add(acc, fm);
            end
          end
        endcase
      end
      cjb_pkg::S_EMIT: begin
        if (kind == 3'b001) begin
          for (int i = 0; i < 3; i++) ja0[rr][i] <= ov[i];
        end
        if (kind == 3'b011) begin
          for (int i = 0; i < 3; i++) ja1[rr][i] <= ov[i];
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/cjb_div.sv =====
// Bit-serial restoring divider with a quotient saturated to the largest positive value.
module cjb_div #(
  parameter int VALUE_WIDTH = cjb_pkg::DEF_VALUE_WIDTH,
  parameter int DIV_WIDTH   = 2 * cjb_pkg::DEF_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [DIV_WIDTH-1:0]   dividend,
  input  logic [VALUE_WIDTH-1:0] divisor,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] quotient
);

  localparam int VW = VALUE_WIDTH;
  localparam int DW = DIV_WIDTH;
  localparam int CW = $clog2(DW + 1);
  localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};

  logic          run;
  logic [CW-1:0] cnt;
  logic [VW:0]   rem;
  logic [VW:0]   rem_sh;
  logic [DW-1:0] dq;
  logic [VW-1:0] dvs;
  logic          ge;

  // One quotient bit per cycle
  assign rem_sh = {rem[VW-1:0], dq[DW-1]};
  assign ge     = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dq  <= dividend;
      dvs <= divisor;
    end else if (run) begin
      rem <= ge ? (rem_sh - {1'b0, dvs}) : rem_sh;
      dq  <= {dq[DW-2:0], ge};
    end
  end

  // Clamp quotients that do not fit the signed range
  assign quotient = (|dq[DW-1:VW-1]) ? VMAX : dq[VW-1:0];

endmodule

// ===== rtl/core/cjb_chk.sv =====
// Port-level checker for the contact Jacobian builder, bound to the top level.
module cjb_chk (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic compute,
  input logic strobe,
  input logic last
);

  // Rows only appear while a compute beat is in progress
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst) strobe |-> busy)
    else $error("row beat outside a compute");

  a_last_strobe: assert property (@(posedge clk) disable iff (rst) last |-> strobe)
    else $error("last without a row beat");

  // A load beat never holds the block
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !compute) |=> !busy)
    else $error("load beat left the block busy");

  // Final row releases the block
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !busy)
    else $error("block still busy after final row");

  // Between two row beats the block stays busy and works on the next row
  a_row_gap: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |=> (busy && !strobe))
    else $error("back-to-back row beats");

endmodule

bind contact_jacobian_builder_core cjb_chk u_cjb_chk (.*);

// ===== tb/sv/tb_contact_jacobian_builder_core.sv =====
// Self-checking testbench for contact_jacobian_builder_core: queued operand and compute beats.
module tb_contact_jacobian_builder_core;

  localparam int VW = cjb_pkg::DEF_VALUE_WIDTH;
  localparam int FB = cjb_pkg::DEF_FRAC_BITS;
  localparam int SLW = cjb_pkg::SLOT_W;
  localparam int NSLOT = cjb_pkg::NUM_SLOTS;
  localparam longint VMAX = (64'sd1 <<< (VW - 1)) - 1;
  localparam longint VMIN = -VMAX - 1;
  localparam longint ONE = 64'sd1 <<< FB;
  localparam int STALL_LIMIT = 20000;
  localparam int TAIL_ITEMS = 20;

  typedef struct {
    logic [SLW-1:0] slot;
    logic signed [VW-1:0] val;
    logic cmp;
    logic drain; // hold off until all rows are back
  } beat_t;

  typedef struct {
    logic [1:0] mat;
    logic [1:0] rw;
    logic pt;
    logic signed [VW-1:0] vx, vy, vz;
    logic lst;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [SLW-1:0] slot = '0;
  logic signed [VW-1:0] operand_value = '0;
  logic compute = 1'b0;
  logic busy, strobe, part, last;
  logic [1:0] which_matrix, row;
  logic signed [VW-1:0] value_x, value_y, value_z;

  beat_t pending[$];
  row_t rows_due[$];
  longint operands[NSLOT];
  bit took = 0;
  bit failed = 0;
  int hold = 0;
  int quiet = 0;

  contact_jacobian_builder_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .slot(slot),
    .operand_value(operand_value), .compute(compute), .strobe(strobe),
    .which_matrix(which_matrix), .row(row), .part(part), .value_x(value_x),
    .value_y(value_y), .value_z(value_z), .last(last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------- fixed-point arithmetic ----------------
  function automatic longint fsat(input longint v);
    if (v > VMAX) return VMAX;
    if (v < VMIN) return VMIN;
    return v;
  endfunction

  // floor of product >> FB, then saturate
  function automatic longint fmul(input longint a, input longint b);
    return fsat((a * b) >>> FB);
  endfunction

  function automatic void cross3(input longint a[3], input longint b[3], output longint o[3]);
    o[0] = fsat(fmul(a[1], b[2]) - fmul(a[2], b[1]));
    o[1] = fsat(fmul(a[2], b[0]) - fmul(a[0], b[2]));
    o[2] = fsat(fmul(a[0], b[1]) - fmul(a[1], b[0]));
  endfunction

  function automatic longint unsigned len_sq(input longint v[3]);
    longint unsigned s;
    s = 0;
    for (int i = 0; i < 3; i++) s += longint'(v[i] * v[i]);
    return s;
  endfunction

  function automatic longint unsigned isqrt(input longint unsigned x);
    longint unsigned r, bt;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt >>= 2;
    while (bt != 0) begin
      if (x >= r + bt) begin
        x -= r + bt;
        r = (r >> 1) + bt;
      end else begin
        r >>= 1;
      end
      bt >>= 2;
    end
    return r;
  endfunction

  function automatic longint sdiv_sat(input longint unsigned mag, input longint unsigned den,
                                      input bit neg);
    longint unsigned q;
    q = mag / den;
    if (q > longint'(VMAX)) q = longint'(VMAX);
    return neg ? fsat(-longint'(q)) : longint'(q);
  endfunction

  function automatic void unit(inout longint v[3]);
    longint unsigned n, mag;
    n = isqrt(len_sq(v));
    if (n == 0) begin
      v = '{0, 0, 0};
      return;
    end
    for (int i = 0; i < 3; i++) begin
      mag = (v[i] < 0) ? -v[i] : v[i];
      v[i] = sdiv_sat(mag << FB, n, v[i] < 0);
    end
  endfunction

  function automatic longint inv_mass(input longint m);
    longint unsigned am;
    if (m == 0) return VMAX;
    am = (m < 0) ? -m : m;
    return sdiv_sat(64'd1 << (2 * FB), am, m < 0);
  endfunction

  // row times 3x3 inverse inertia stored row-major from slot base
  function automatic void times_inertia(input longint r[3], input int base, output longint o[3]);
    longint acc;
    for (int j = 0; j < 3; j++) begin
      acc = 0;
      for (int k = 0; k < 3; k++) acc = fsat(acc + fmul(r[k], operands[base + 3 * k + j]));
      o[j] = acc;
    end
  endfunction

  // store the operand; on compute queue all 24 Jacobian rows
  task automatic build_jacobian(input beat_t b);
    longint nrm[3], tan[3], bin[3], r0[3], r1[3], ax[3], fr[3], v[3], ang[3];
    longint jac[4][3][2][3];
    longint im0, im1;
    row_t e;
    int k;
    operands[b.slot] = b.val;
    if (!b.cmp) return;
    for (int i = 0; i < 3; i++) begin
      nrm[i] = operands[3 + i];
      r0[i] = fsat(operands[i] - operands[6 + i]);
      r1[i] = fsat(operands[i] - operands[9 + i]);
    end
    ax = '{0, 0, ONE};
    cross3(nrm, ax, tan);
    // tangent too short: fall back to n x X
    if (len_sq(tan) <= ((64'd1 << (2 * FB - 12)) / cjb_pkg::FIVE_POW_12)) begin
      ax = '{ONE, 0, 0};
      cross3(nrm, ax, tan);
    end
    unit(tan);
    cross3(nrm, tan, bin);
    unit(bin);
    im0 = inv_mass(operands[12]);
    im1 = inv_mass(operands[13]);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) fr[c] = (r == 0) ? nrm[c] : (r == 1) ? tan[c] : bin[c];
      cross3(r0, fr, v);
      for (int c = 0; c < 3; c++) jac[0][r][1][c] = v[c];
      cross3(r1, fr, v);
      for (int c = 0; c < 3; c++) begin
        jac[0][r][0][c] = fr[c];
        jac[1][r][0][c] = fsat(-fr[c]);
        jac[1][r][1][c] = fsat(-v[c]);
        jac[2][r][0][c] = fmul(im0, fr[c]);
        jac[3][r][0][c] = fmul(im1, jac[1][r][0][c]);
      end
      for (int c = 0; c < 3; c++) v[c] = jac[0][r][1][c];
      times_inertia(v, cjb_pkg::SLOT_I0, ang);
      for (int c = 0; c < 3; c++) jac[2][r][1][c] = ang[c];
      for (int c = 0; c < 3; c++) v[c] = jac[1][r][1][c];
      times_inertia(v, cjb_pkg::SLOT_I1, ang);
      for (int c = 0; c < 3; c++) jac[3][r][1][c] = ang[c];
    end
    k = 0;
    for (int m = 0; m < 4; m++)
      for (int r = 0; r < 3; r++)
        for (int p = 0; p < 2; p++) begin
          e.mat = 2'(m);
          e.rw = 2'(r);
          e.pt = 1'(p);
          e.vx = VW'(jac[m][r][p][0]);
          e.vy = VW'(jac[m][r][p][1]);
          e.vz = VW'(jac[m][r][p][2]);
          e.lst = (k == 23);
          rows_due.insert(rows_due.size(), e);
          k++;
        end
  endtask

  // ---------------- stimulus ----------------
  function automatic logic signed [VW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return VW'(ONE);
      2: return VW'(-ONE);
      3: return VW'(VMAX);
      4: return VW'(VMIN);
      5, 6: return VW'($urandom);
      default: return VW'($signed($urandom_range(0, 8 << FB)) - (4 << FB));
    endcase
  endfunction

  task automatic add_beat(input int s, input logic signed [VW-1:0] v, input bit c);
    beat_t b;
    b.slot = SLW'(s);
    b.val = v;
    b.cmp = c;
    b.drain = 0;
    pending.insert(pending.size(), b);
  endtask

  task automatic add_drain();
    beat_t b;
    b = '{default: '0};
    b.drain = 1;
    pending.insert(pending.size(), b);
  endtask

  initial begin
    int n, s;
    // full load, normal along z so the tangent falls back to n x X, mass0 zero
    for (int i = 0; i < NSLOT; i++) begin
      logic signed [VW-1:0] v;
      v = VW'($signed($urandom_range(0, 4 << FB)) - (2 << FB));
      if (i == 3 || i == 4 || i == 12) v = 0;
      if (i == 5) v = VW'(ONE);
      if (i == 13) v = VW'(-(2 * ONE));
      add_beat(i, v, i == NSLOT - 1);
    end
    // zero normal
    add_beat(3, 0, 0);
    add_beat(4, 0, 0);
    add_beat(5, 0, 1);
    // extremes in contact point, body positions, normal, mass1 and one inertia entry, mass0 of one LSB
    add_beat(0, VW'(VMAX), 0);
    add_beat(6, VW'(VMIN), 0);
    add_beat(9, VW'(VMAX), 0);
    add_beat(12, 1, 0);
    add_beat(13, VW'(VMIN), 0);
    add_beat(14, VW'(VMAX), 0);
    add_beat(3, VW'(VMAX), 0);
    add_beat(4, VW'(VMIN), 0);
    add_beat(5, VW'(VMAX), 1);
    // plain unit normal along x, tiny negative mass
    add_beat(3, VW'(ONE), 0);
    add_beat(4, 0, 0);
    add_beat(5, 0, 0);
    add_beat(12, -1, 1);
    // random contacts: a few operand updates then compute
    for (int c = 0; c < 12; c++) begin
      if (c == 4) add_drain();
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
        s = $urandom_range(0, NSLOT - 1);
        add_beat(s, pick_value(), 0);
      end
      // sometimes a z-aligned normal to hit the fallback
      if ($urandom_range(0, 3) == 0) begin
        add_beat(3, 0, 0);
        add_beat(4, 0, 0);
      end
      add_beat($urandom_range(0, NSLOT - 1), pick_value(), 1);
    end
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    while (pending.size() != 0 || start || rows_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (!failed && rows_due.size() == 0) begin
      $display("contact_jacobian_builder_core test passed");
    end else begin
      $display("contact_jacobian_builder_core test failed");
    end
    $finish;
  end

  // ---------------- driver ----------------
  always @(negedge clk) begin
    if (!rst) begin
      if (start && !took) begin
        // beat still waiting for busy to drop
      end else if (hold > 0) begin
        hold <= hold - 1;
        start <= 1'b0;
      end else if (pending.size() == 0) begin
        start <= 1'b0;
      end else if (pending[0].drain) begin
        if (rows_due.size() == 0) void'(pending.pop_front());
        start <= 1'b0;
      end else if (pending.size() > TAIL_ITEMS && $urandom_range(0, 4) == 0) begin
        hold <= $urandom_range(0, 16);
        start <= 1'b0;
      end else begin
        beat_t b;
        b = pending.pop_front();
        slot <= b.slot;
        operand_value <= b.val;
        compute <= b.cmp;
        start <= 1'b1;
      end
      took = 0;
    end
  end

  // ---------------- monitor, checker and watchdog ----------------
  always @(posedge clk) begin
    if (!rst) begin
      bit moved;
      moved = 0;
      if (start && !busy) begin
        beat_t b;
        b.slot = slot;
        b.val = operand_value;
        b.cmp = compute;
        b.drain = 0;
        build_jacobian(b);
        took = 1;
        moved = 1;
      end
      if (strobe) begin
        if (rows_due.size() == 0) begin
          $display("%0t: unexpected row mat=%0d row=%0d part=%0d", $time,
                   which_matrix, row, part);
          failed = 1;
        end else begin
          row_t e;
          e = rows_due.pop_front();
          moved = 1;
          if (which_matrix !== e.mat || row !== e.rw || part !== e.pt ||
              value_x !== e.vx || value_y !== e.vy || value_z !== e.vz || last !== e.lst) begin
            $display("%0t: row mismatch expected m=%0d r=%0d p=%0d x=%0d y=%0d z=%0d last=%0d",
                     $time, e.mat, e.rw, e.pt, e.vx, e.vy, e.vz, e.lst);
            $display("%0t:              actual   m=%0d r=%0d p=%0d x=%0d y=%0d z=%0d last=%0d",
                     $time, which_matrix, row, part, value_x, value_y, value_z, last);
            failed = 1;
          end
        end
      end
      quiet = moved ? 0 : quiet + 1;
      if (quiet >= STALL_LIMIT) begin
        $display("%0t: timeout, no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("contact_jacobian_builder_core test failed");
        $finish;
      end
    end
  end

endmodule
